@@ rtl/core/vector_clock_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Vector clock unit assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef VECTOR_CLOCK_UNIT_MACROS_SVH
`define VECTOR_CLOCK_UNIT_MACROS_SVH

// same-cycle implication
`define VCU_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("vcu: same-cycle check failed");

// next-cycle implication
`define VCU_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("vcu: next-cycle check failed");

`endif

@@ rtl/core/vcu_pkg.sv @@
// ----------------------------------------------------------------------------
// Vector clock unit package
// Command codes, field widths and the item types passed between stages.
// ----------------------------------------------------------------------------
package vcu_pkg;

  localparam int unsigned CmdW = 3;
  localparam int unsigned IdW  = 4;
  localparam int unsigned ValW = 31;

  localparam logic [ValW-1:0] ValMax = 31'h7FFF_FFFF;

  typedef enum logic [CmdW-1:0] {
    CMD_INC     = 3'd0,
    CMD_SET     = 3'd1,
    CMD_MERGE   = 3'd2,
    CMD_COMPARE = 3'd3,
    CMD_READ    = 3'd4,
    CMD_CLEAR   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_BUMP = 3'b100
  } bstate_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [IdW-1:0]  id;
    logic            ok;
    logic [ValW-1:0] value;
    logic            has;
    logic            last;
  } op_t;

  typedef struct packed {
    logic            compare_le;
    logic            compare_done;
    logic            read_present;
    logic [ValW-1:0] read_value;
  } res_t;

endpackage

@@ rtl/core/vcu_front.sv @@
// ----------------------------------------------------------------------------
// Vector clock unit front end
// Accepts input items, decodes the command and range-checks the index.
// ----------------------------------------------------------------------------
module vcu_front #(
  parameter int unsigned NUM_PROCS = 16
) (
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [vcu_pkg::CmdW-1:0]    command_i,
  input  logic [vcu_pkg::IdW-1:0]     entry_id_i,
  input  logic [vcu_pkg::ValW-1:0]    entry_value_i,
  input  logic                        has_entry_i,
  input  logic                        last_i,
  output logic                        push_o,
  input  logic                        full_i,
  output vcu_pkg::op_t                op_o
);

  vcu_pkg::cmd_e cmd;

  always_comb begin
    case (command_i)
      vcu_pkg::CMD_INC:     cmd = vcu_pkg::CMD_INC;
      vcu_pkg::CMD_SET:     cmd = vcu_pkg::CMD_SET;
      vcu_pkg::CMD_MERGE:   cmd = vcu_pkg::CMD_MERGE;
      vcu_pkg::CMD_COMPARE: cmd = vcu_pkg::CMD_COMPARE;
      vcu_pkg::CMD_CLEAR:   cmd = vcu_pkg::CMD_CLEAR;
      default:              cmd = vcu_pkg::CMD_READ;
    endcase
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  assign op_o.cmd   = cmd;
  assign op_o.id    = entry_id_i;
  assign op_o.ok    = (32'(entry_id_i) < NUM_PROCS);
  assign op_o.value = entry_value_i;
  assign op_o.has   = has_entry_i;
  assign op_o.last  = last_i;

endmodule

@@ rtl/core/vcu_queue.sv @@
// ----------------------------------------------------------------------------
// Vector clock unit item queue
// Two-entry queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module vcu_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  vcu_pkg::op_t op_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         pop_i,
  output vcu_pkg::op_t op_o
);

  vcu_pkg::op_t slot_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign op_o    = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

@@ rtl/core/vcu_back.sv @@
// ----------------------------------------------------------------------------
// Vector clock unit back end
// Executes items against the counter memory and holds the result register.
// ----------------------------------------------------------------------------
`include "vector_clock_unit_macros.svh"

module vcu_back #(
  parameter int unsigned NUM_PROCS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [vcu_pkg::IdW-1:0] own_id_i,
  input  logic                    op_valid_i,
  input  vcu_pkg::op_t            op_i,
  output logic                    op_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output vcu_pkg::res_t           out_o
);

  localparam int unsigned IW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

  vcu_pkg::bstate_e         state_q, state_d;
  vcu_pkg::op_t             op_q;
  logic [vcu_pkg::ValW-1:0] mem_q [NUM_PROCS];
  logic [vcu_pkg::ValW-1:0] rdata_q;
  logic [IW-1:0]            raddr, waddr;
  logic                     we;
  logic [vcu_pkg::ValW-1:0] wdata;

  logic [NUM_PROCS-1:0]     present_q, present_d;
  logic [NUM_PROCS-1:0]     seen_q, seen_d;
  logic                     failed_q, failed_d;

  logic [vcu_pkg::ValW-1:0] res_val_q, res_val_d;
  logic                     res_pres_q, res_pres_d;
  logic                     wrote_q, wrote_d;
  logic [vcu_pkg::ValW-1:0] wval_q, wval_d;

  logic                     out_valid_q;
  vcu_pkg::res_t            out_q, out_d;
  logic                     out_load, out_ready_w;

  logic [IW-1:0]            idx_i, idx_q, own_idx;
  logic                     own_ok;
  logic                     cur_pres;
  logic [vcu_pkg::ValW-1:0] cur_val, inc_val, max_val;
  logic [vcu_pkg::ValW-1:0] own_cur, own_inc;
  logic                     exec_pres;
  logic [vcu_pkg::ValW-1:0] exec_val;
  logic                     cmp_done, cmp_le;

  assign idx_i   = IW'(op_i.id);
  assign idx_q   = IW'(op_q.id);
  assign own_idx = IW'(own_id_i);
  assign own_ok  = (32'(own_id_i) < NUM_PROCS);

  assign cur_pres = op_q.ok && present_q[idx_q];
  assign cur_val  = cur_pres ? rdata_q : '0;
  assign inc_val  = (cur_val == vcu_pkg::ValMax) ? cur_val : cur_val + 31'd1;
  assign max_val  = (cur_val > op_q.value) ? cur_val : op_q.value;

  assign own_cur  = (wrote_q && (own_idx == idx_q)) ? wval_q
                  : (present_q[own_idx] ? rdata_q : '0);
  assign own_inc  = (own_cur == vcu_pkg::ValMax) ? own_cur : own_cur + 31'd1;

  assign out_ready_w = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d    = state_q;
    op_pop_o   = 1'b0;
    raddr      = idx_i;
    we         = 1'b0;
    waddr      = idx_q;
    wdata      = inc_val;
    present_d  = present_q;
    seen_d     = seen_q;
    failed_d   = failed_q;
    res_val_d  = res_val_q;
    res_pres_d = res_pres_q;
    wrote_d    = wrote_q;
    wval_d     = wval_q;
    out_load   = 1'b0;
    out_d      = out_q;
    cmp_done   = 1'b0;
    cmp_le     = 1'b0;
    exec_val   = cur_val;
    exec_pres  = cur_pres;
    case (state_q)
      vcu_pkg::ST_IDLE: begin
        if (op_valid_i && out_ready_w) begin
          op_pop_o = 1'b1;
          state_d  = vcu_pkg::ST_EXEC;
        end
      end
      vcu_pkg::ST_EXEC: begin
        raddr = own_idx;
        case (op_q.cmd)
          vcu_pkg::CMD_INC: begin
            we    = op_q.ok;
            wdata = inc_val;
          end
          vcu_pkg::CMD_SET: begin
            we    = op_q.ok;
            wdata = op_q.value;
          end
          vcu_pkg::CMD_MERGE: begin
            we    = op_q.ok && op_q.has;
            wdata = max_val;
          end
          vcu_pkg::CMD_COMPARE: begin
            if (op_q.ok && op_q.has) begin
              seen_d[idx_q] = 1'b1;
              if (cur_pres && (rdata_q > op_q.value)) begin
                failed_d = 1'b1;
              end
            end
            if (op_q.last) begin
              cmp_done = 1'b1;
              cmp_le   = !failed_d && ((present_q & ~seen_d) == '0);
              seen_d   = '0;
              failed_d = 1'b0;
            end
          end
          vcu_pkg::CMD_CLEAR: begin
            present_d = '0;
            seen_d    = '0;
            failed_d  = 1'b0;
            exec_val  = '0;
            exec_pres = 1'b0;
          end
          default: ;
        endcase
        if (we) begin
          present_d[idx_q] = 1'b1;
          exec_val         = wdata;
          exec_pres        = 1'b1;
        end
        if ((op_q.cmd == vcu_pkg::CMD_MERGE) && op_q.last && own_ok) begin
          res_val_d  = exec_val;
          res_pres_d = exec_pres;
          wrote_d    = we;
          wval_d     = wdata;
          state_d    = vcu_pkg::ST_BUMP;
        end else begin
          out_load           = 1'b1;
          out_d.read_value   = exec_val;
          out_d.read_present = exec_pres;
          out_d.compare_done = cmp_done;
          out_d.compare_le   = cmp_le;
          state_d            = vcu_pkg::ST_IDLE;
        end
      end
      vcu_pkg::ST_BUMP: begin
        we                 = 1'b1;
        waddr              = own_idx;
        wdata              = own_inc;
        present_d[own_idx] = 1'b1;
        out_load           = 1'b1;
        if (op_q.ok && (own_idx == idx_q)) begin
          out_d.read_value   = own_inc;
          out_d.read_present = 1'b1;
        end else begin
          out_d.read_value   = res_val_q;
          out_d.read_present = res_pres_q;
        end
        out_d.compare_done = 1'b0;
        out_d.compare_le   = 1'b0;
        state_d            = vcu_pkg::ST_IDLE;
      end
      default: begin
        state_d = vcu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vcu_pkg::ST_IDLE;
      present_q   <= '0;
      seen_q      <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      present_q <= present_d;
      seen_q    <= seen_d;
      failed_q  <= failed_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      op_q <= op_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
    res_val_q  <= res_val_d;
    res_pres_q <= res_pres_d;
    wrote_q    <= wrote_d;
    wval_q     <= wval_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  `VCU_ASSERT_IMP(a_pop_out_free, clk_i, rst_ni, op_pop_o, out_ready_w)
  `VCU_ASSERT_IMP(a_load_empty, clk_i, rst_ni, out_load, !out_valid_q)
  `VCU_ASSERT_IMP(a_bump_after_exec, clk_i, rst_ni, state_q == vcu_pkg::ST_BUMP, $past(state_q) == vcu_pkg::ST_EXEC)
  `VCU_ASSERT_NXT(a_cmp_end_clears, clk_i, rst_ni, out_load && out_d.compare_done, (seen_q == '0) && !failed_q)
  `VCU_ASSERT_IMP(a_le_needs_done, clk_i, rst_ni, out_valid_q && out_q.compare_le, out_q.compare_done)

endmodule

@@ rtl/core/vector_clock_unit.sv @@
// ----------------------------------------------------------------------------
// Vector clock unit
// Vector clock of NUM_PROCS counters with present bits, driven by commands.
//
// Input items arrive on s_axis: tuser carries the command and the has-entry
// flag, tdata the entry index and value, tlast the end of a merge or compare
// run. Each item gives exactly one result item on m_axis: the counter at the
// addressed index after the command, its present bit, and the compare
// outcome on the last item of a compare run. own_id is written through
// cfg_we_i / cfg_wdata_i; the user writes it only while the block is idle;
// the block has no check for this. An item is registered with the registered
// read of its counter, then updated while loading the result register; a merge
// last item adds a read-modify-write of the own entry if own_id is in range.
// A new item is taken only once the previous one is done and the result is free.
// Reset empties the clock (all entries absent) and clears own_id; the
// counter memory is not swept, absent entries read as zero.
// A stalled result holds m_axis; a two-entry queue behind s_axis keeps
// taking items until full.
// ----------------------------------------------------------------------------
module vector_clock_unit #(
  parameter int unsigned NUM_PROCS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // entry_id[3:0], entry_value[34:4], zero pad
  input  logic [3:0]  s_axis_tuser,  // command[2:0], has_entry[3]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // read_value[30:0], read_present[31],
                                     // compare_done[32], compare_le[33], zero pad
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i
);

  logic [vcu_pkg::IdW-1:0] own_id_q;
  logic                    push, full, q_valid, pop;
  vcu_pkg::op_t            op_in, op_head;
  vcu_pkg::res_t           res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0;
    end else if (cfg_we_i) begin
      own_id_q <= cfg_wdata_i;
    end
  end

  vcu_front #(
    .NUM_PROCS(NUM_PROCS)
  ) u_front (
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .command_i    (s_axis_tuser[2:0]),
    .entry_id_i   (s_axis_tdata[3:0]),
    .entry_value_i(s_axis_tdata[34:4]),
    .has_entry_i  (s_axis_tuser[3]),
    .last_i       (s_axis_tlast),
    .push_o       (push),
    .full_i       (full),
    .op_o         (op_in)
  );

  vcu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (op_in),
    .full_o (full),
    .valid_o(q_valid),
    .pop_i  (pop),
    .op_o   (op_head)
  );

  vcu_back #(
    .NUM_PROCS(NUM_PROCS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .own_id_i   (own_id_q),
    .op_valid_i (q_valid),
    .op_i       (op_head),
    .op_pop_o   (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_o      (res)
  );

  assign m_axis_tdata = {6'b0, res.compare_le, res.compare_done, res.read_present,
                         res.read_value};

endmodule
